// ----- design/xoodoo_pkg.sv -----
// shared types, constants and round constant table for the xoodoo permutation
// depends on nothing; every other file of the block refers to it by scoped names
`default_nettype none

package xoodoo_pkg;

    localparam int LANE_W    = 32;
    localparam int LANE_CNT  = 12;
    localparam int CFG_W     = 4;
    localparam int RC_CNT    = 12;
    localparam int RC_IDX_W  = 4;

    // configuration register indexes
    localparam logic CFG_ROUND_COUNT = 1'b0;
    localparam logic CFG_START_INDEX = 1'b1;

    localparam logic [CFG_W-1:0] ROUND_COUNT_RST = 4'd12;
    localparam logic [CFG_W-1:0] START_INDEX_RST = 4'd0;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [LANE_CNT-1:0] lanes_t;

    typedef struct packed {
        lane_t lane_p0_x0;
        lane_t lane_p0_x1;
        lane_t lane_p0_x2;
        lane_t lane_p0_x3;
        lane_t lane_p1_x0;
        lane_t lane_p1_x1;
        lane_t lane_p1_x2;
        lane_t lane_p1_x3;
        lane_t lane_p2_x0;
        lane_t lane_p2_x1;
        lane_t lane_p2_x2;
        lane_t lane_p2_x3;
    } in_beat_t;

    typedef struct packed {
        lane_t out_p0_x0;
        lane_t out_p0_x1;
        lane_t out_p0_x2;
        lane_t out_p0_x3;
        lane_t out_p1_x0;
        lane_t out_p1_x1;
        lane_t out_p1_x2;
        lane_t out_p1_x3;
        lane_t out_p2_x0;
        lane_t out_p2_x1;
        lane_t out_p2_x2;
        lane_t out_p2_x3;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic                load;
        logic                round_en;
        logic [RC_IDX_W-1:0] rc_idx;
    } dp_cmd_t;

    function automatic lane_t round_const(input logic [RC_IDX_W-1:0] idx);
        lane_t rc;
        case (idx)
            4'd0:    rc = 32'h0000_0058;
            4'd1:    rc = 32'h0000_0038;
            4'd2:    rc = 32'h0000_03C0;
            4'd3:    rc = 32'h0000_00D0;
            4'd4:    rc = 32'h0000_0120;
            4'd5:    rc = 32'h0000_0014;
            4'd6:    rc = 32'h0000_0060;
            4'd7:    rc = 32'h0000_002C;
            4'd8:    rc = 32'h0000_0380;
            4'd9:    rc = 32'h0000_00F0;
            4'd10:   rc = 32'h0000_01A0;
            4'd11:   rc = 32'h0000_0012;
            default: rc = '0;
        endcase
        return rc;
    endfunction

endpackage

`default_nettype wire

// ----- design/xoodoo_ctrl.sv -----
// round sequencer and configuration registers of the xoodoo permutation
// depends on xoodoo_pkg
`default_nettype none

module xoodoo_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [xoodoo_pkg::CFG_W-1:0]        cfg_data,
    output xoodoo_pkg::dp_cmd_t                      cmd,
    output logic                                     busy,
    output logic                                     done
);

    xoodoo_pkg::ctrl_state_t               state_reg, state_next;
    logic [xoodoo_pkg::CFG_W-1:0]          round_count_reg;
    logic [xoodoo_pkg::CFG_W-1:0]          start_index_reg;
    logic [xoodoo_pkg::CFG_W-1:0]          rounds_left_reg, rounds_left_next;
    logic [xoodoo_pkg::RC_IDX_W-1:0]       rc_idx_reg, rc_idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= xoodoo_pkg::ROUND_COUNT_RST;
            start_index_reg <= xoodoo_pkg::START_INDEX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xoodoo_pkg::CFG_ROUND_COUNT: round_count_reg <= cfg_data;
                xoodoo_pkg::CFG_START_INDEX: start_index_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= xoodoo_pkg::ST_IDLE;
            rounds_left_reg <= '0;
            rc_idx_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rounds_left_reg <= rounds_left_next;
            rc_idx_reg      <= rc_idx_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        rounds_left_next = rounds_left_reg;
        rc_idx_next      = rc_idx_reg;
        cmd.load         = 1'b0;
        cmd.round_en     = 1'b0;
        cmd.rc_idx       = rc_idx_reg;
        busy             = 1'b1;
        done             = 1'b0;
        case (state_reg)
            xoodoo_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load         = 1'b1;
                    rounds_left_next = round_count_reg;
                    // start index reduced mod 12 once; it is below 16
                    if (start_index_reg >= 4'(xoodoo_pkg::RC_CNT))
                        rc_idx_next = start_index_reg - 4'(xoodoo_pkg::RC_CNT);
                    else
                        rc_idx_next = start_index_reg;
                    if (round_count_reg == '0)
                        state_next = xoodoo_pkg::ST_DONE;
                    else
                        state_next = xoodoo_pkg::ST_RUN;
                end
            end
            xoodoo_pkg::ST_RUN:
            begin
                cmd.round_en     = 1'b1;
                rounds_left_next = rounds_left_reg - 4'd1;
                if (rc_idx_reg == 4'(xoodoo_pkg::RC_CNT - 1))
                    rc_idx_next = '0;
                else
                    rc_idx_next = rc_idx_reg + 4'd1;
                if (rounds_left_reg == 4'd1)
                    state_next = xoodoo_pkg::ST_DONE;
            end
            xoodoo_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = xoodoo_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = xoodoo_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/xoodoo_dp.sv -----
// state register and one-round xoodoo logic
// depends on xoodoo_pkg
`default_nettype none

module xoodoo_dp (
    input  wire logic                   clk,
    input  wire xoodoo_pkg::dp_cmd_t    cmd,
    input  wire xoodoo_pkg::in_beat_t   state_in,
    output xoodoo_pkg::out_beat_t       state_out
);

    xoodoo_pkg::lanes_t lanes_reg, lanes_next;
    xoodoo_pkg::lanes_t load_lanes;
    xoodoo_pkg::lanes_t round_lanes;

    function automatic xoodoo_pkg::lane_t rotl(input xoodoo_pkg::lane_t v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic xoodoo_pkg::lanes_t do_round(input xoodoo_pkg::lanes_t a_in,
                                                    input xoodoo_pkg::lane_t rc);
        xoodoo_pkg::lanes_t a;
        xoodoo_pkg::lanes_t b;
        xoodoo_pkg::lanes_t r;
        xoodoo_pkg::lane_t  par [4];
        xoodoo_pkg::lane_t  eff [4];
        xoodoo_pkg::lane_t  t   [4];
        a = a_in;
        for (int x = 0; x < 4; x++)
            par[x] = a[x] ^ a[4 + x] ^ a[8 + x];
        // theta
        for (int x = 0; x < 4; x++)
            eff[x] = rotl(par[(x + 3) % 4], 5) ^ rotl(par[(x + 3) % 4], 14);
        for (int p = 0; p < 3; p++)
            for (int x = 0; x < 4; x++)
                a[p * 4 + x] = a[p * 4 + x] ^ eff[x];
        // rho-west
        for (int x = 0; x < 4; x++)
            t[x] = a[4 + (x + 3) % 4];
        for (int x = 0; x < 4; x++)
        begin
            a[4 + x] = t[x];
            a[8 + x] = rotl(a[8 + x], 11);
        end
        // iota
        a[0] = a[0] ^ rc;
        // chi
        for (int x = 0; x < 4; x++)
        begin
            b[x]     = a[x]     ^ (~a[4 + x] & a[8 + x]);
            b[4 + x] = a[4 + x] ^ (~a[8 + x] & a[x]);
            b[8 + x] = a[8 + x] ^ (~a[x]     & a[4 + x]);
        end
        // rho-east
        for (int x = 0; x < 4; x++)
        begin
            r[x]     = b[x];
            r[4 + x] = rotl(b[4 + x], 1);
            r[8 + x] = rotl(b[8 + (x + 2) % 4], 8);
        end
        return r;
    endfunction

    always_comb
    begin
        load_lanes[0]  = state_in.lane_p0_x0;
        load_lanes[1]  = state_in.lane_p0_x1;
        load_lanes[2]  = state_in.lane_p0_x2;
        load_lanes[3]  = state_in.lane_p0_x3;
        load_lanes[4]  = state_in.lane_p1_x0;
        load_lanes[5]  = state_in.lane_p1_x1;
        load_lanes[6]  = state_in.lane_p1_x2;
        load_lanes[7]  = state_in.lane_p1_x3;
        load_lanes[8]  = state_in.lane_p2_x0;
        load_lanes[9]  = state_in.lane_p2_x1;
        load_lanes[10] = state_in.lane_p2_x2;
        load_lanes[11] = state_in.lane_p2_x3;
    end

    assign round_lanes = do_round(lanes_reg, xoodoo_pkg::round_const(cmd.rc_idx));

    always_comb
    begin
        if (cmd.load)
            lanes_next = load_lanes;
        else if (cmd.round_en)
            lanes_next = round_lanes;
        else
            lanes_next = lanes_reg;
    end

    always_ff @(posedge clk)
    begin
        lanes_reg <= lanes_next;
    end

    always_comb
    begin
        state_out.out_p0_x0 = lanes_reg[0];
        state_out.out_p0_x1 = lanes_reg[1];
        state_out.out_p0_x2 = lanes_reg[2];
        state_out.out_p0_x3 = lanes_reg[3];
        state_out.out_p1_x0 = lanes_reg[4];
        state_out.out_p1_x1 = lanes_reg[5];
        state_out.out_p1_x2 = lanes_reg[6];
        state_out.out_p1_x3 = lanes_reg[7];
        state_out.out_p2_x0 = lanes_reg[8];
        state_out.out_p2_x1 = lanes_reg[9];
        state_out.out_p2_x2 = lanes_reg[10];
        state_out.out_p2_x3 = lanes_reg[11];
    end

endmodule

`default_nettype wire

// ----- design/xoodoo_permutation.sv -----
// top level of the xoodoo-384 forward permutation: controller plus round datapath
// depends on xoodoo_pkg, xoodoo_ctrl and xoodoo_dp
//
// channel   | signals                        | direction | handshake
// ----------+--------------------------------+-----------+-------------------------
// input     | start, busy, state_in          | in        | beat taken on start & !busy
// result    | done, state_out                | out       | one-cycle strobe on done
// config    | cfg_we, cfg_index, cfg_data    | in        | written when cfg_we is high
//
// one input beat runs from the accept cycle through the done cycle:
// the accept cycle loads the state, the rounds then run through the single shared round unit,
// and the done cycle shows the result; a round count of zero shows the input in the cycle
// right after the accept cycle
// busy is high in the run and done states, so start is ignored then
// asynchronous active-low reset puts round_count at 12 and start_index at 0
// the result is valid only in the done cycle; the receiver cannot stall it
`default_nettype none

module xoodoo_permutation (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire xoodoo_pkg::in_beat_t            state_in,
    output logic                                 busy,
    output logic                                 done,
    output xoodoo_pkg::out_beat_t                state_out,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [xoodoo_pkg::CFG_W-1:0]    cfg_data
);

    // commands from the sequencer: load the state, run one round, constant index
    xoodoo_pkg::dp_cmd_t cmd;

    // sequencer: holds the config registers, counts rounds, walks the constant index
    xoodoo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    // datapath: 384-bit state register and one full round of logic
    xoodoo_dp u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .state_in  (state_in),
        .state_out (state_out)
    );

endmodule

`default_nettype wire
